// ===== hdl/window_size_hint_constrain_top_assert.svh =====
// assertion macros for the window size hint constrain block
`ifndef WINDOW_SIZE_HINT_CONSTRAIN_TOP_ASSERT_SVH
`define WINDOW_SIZE_HINT_CONSTRAIN_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WSHC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WSHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wshc_pkg.sv =====
// types and constants shared by the window size hint constrain block
package wshc_pkg;

   localparam int SIZE_BITS      = 16;
   localparam int ORG_BITS       = 18;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int FLAG_BITS      = 4;
   localparam int CHAIN_CELLS    = SIZE_BITS;
   localparam int PIPE_DEPTH     = CHAIN_CELLS + 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HINT_FLAGS     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_SIZE      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SIZE       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SIZE       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_INCREMENT = 3'd4;

   localparam int FLAG_INC  = 0;
   localparam int FLAG_BASE = 1;
   localparam int FLAG_MIN  = 2;
   localparam int FLAG_MAX  = 3;

   typedef logic [SIZE_BITS-1:0] size_type;

   typedef struct packed {
      logic [FLAG_BITS-1:0] flags;
      size_type [1:0]       base_sz;
      size_type [1:0]       min_sz;
      size_type [1:0]       max_sz;
      size_type [1:0]       inc;
   } hint_cfg_type;

   typedef struct packed {
      size_type                    size;
      logic                        neg;
      logic                        en;
      size_type                    dvd;
      size_type                    rem;
      logic signed [ORG_BITS-1:0]  anchor;
      logic                        back;
   } lane_type;

   typedef struct packed {
      lane_type [1:0] lane;
   } cell_data_type;

endpackage

// ===== hdl/wshc_prep.sv =====
// front stages: corner differences, saturation and offset from the snap base
module wshc_prep #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_BITS-1:0]  anchor_x,
   input  logic signed [COORD_BITS-1:0]  anchor_y,
   input  logic signed [COORD_BITS-1:0]  pointer_x,
   input  logic signed [COORD_BITS-1:0]  pointer_y,
   input  wshc_pkg::hint_cfg_type        cfg,
   output logic                          out_valid,
   input  logic                          out_ready,
   output wshc_pkg::cell_data_type       out_data
);
   import wshc_pkg::*;

   logic signed [COORD_BITS-1:0] anc [2];
   logic signed [COORD_BITS-1:0] pnt [2];
   cell_data_type f_data_in, f_data_ff, p_data_in, p_data_ff;
   logic f_valid_ff, p_valid_ff, f_ready, p_ready;

   assign anc[0] = anchor_x;
   assign anc[1] = anchor_y;
   assign pnt[0] = pointer_x;
   assign pnt[1] = pointer_y;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic signed [COORD_BITS:0]          diff;
      logic [COORD_BITS:0]                 mag;
      logic [COORD_BITS+SIZE_BITS:0]       mag_wide;
      logic [COORD_BITS+ORG_BITS-1:0]      anc_wide;
      size_type                            base;
      logic [SIZE_BITS:0]                  ofs;
      logic [SIZE_BITS:0]                  ofs_mag;

      assign diff     = {anc[a][COORD_BITS-1], anc[a]} - {pnt[a][COORD_BITS-1], pnt[a]};
      assign mag      = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
      assign mag_wide = {{SIZE_BITS{1'b0}}, mag};
      assign anc_wide = {{ORG_BITS{anc[a][COORD_BITS-1]}}, anc[a]};

      always_comb begin
         f_data_in.lane[a]        = '0;
         f_data_in.lane[a].size   = (|mag_wide[COORD_BITS+SIZE_BITS:SIZE_BITS]) ?
                                    '1 : mag_wide[SIZE_BITS-1:0];
         f_data_in.lane[a].anchor = $signed(anc_wide[ORG_BITS-1:0]);
         f_data_in.lane[a].back   = !diff[COORD_BITS] && (diff != '0);
      end

      // snap base selection
      always_comb begin
         priority if (cfg.flags[FLAG_BASE]) begin
            base = cfg.base_sz[a];
         end else if (cfg.flags[FLAG_MIN]) begin
            base = cfg.min_sz[a];
         end else begin
            base = '0;
         end
      end

      assign ofs     = {1'b0, f_data_ff.lane[a].size} - {1'b0, base};
      assign ofs_mag = ofs[SIZE_BITS] ? (~ofs + 1'b1) : ofs;

      always_comb begin
         p_data_in.lane[a]     = f_data_ff.lane[a];
         p_data_in.lane[a].neg = ofs[SIZE_BITS];
         p_data_in.lane[a].en  = cfg.flags[FLAG_INC] && (cfg.inc[a] != '0);
         p_data_in.lane[a].dvd = ofs_mag[SIZE_BITS-1:0];
         p_data_in.lane[a].rem = '0;
      end
   end

   assign p_ready  = !p_valid_ff || out_ready;
   assign f_ready  = !f_valid_ff || p_ready;
   assign in_ready = f_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         if (f_ready) begin
            f_valid_ff <= in_valid;
         end
         if (p_ready) begin
            p_valid_ff <= f_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && in_valid) begin
         f_data_ff <= f_data_in;
      end
      if (p_ready && f_valid_ff) begin
         p_data_ff <= p_data_in;
      end
   end

   assign out_valid = p_valid_ff;
   assign out_data  = p_data_ff;

endmodule

// ===== hdl/wshc_cell.sv =====
// one remainder cell: shifts in one dividend bit per lane and subtracts the step
module wshc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  wshc_pkg::cell_data_type   in_data,
   input  wshc_pkg::size_type [1:0]  inc,
   output logic                      out_valid,
   input  logic                      out_ready,
   output wshc_pkg::cell_data_type   out_data
);
   import wshc_pkg::*;

   cell_data_type data_in, data_ff;
   logic valid_ff;

   for (genvar a = 0; a < 2; a++) begin : g_lane
      logic [SIZE_BITS:0] trial;
      logic [SIZE_BITS:0] diff;

      assign trial = {in_data.lane[a].rem, in_data.lane[a].dvd[SIZE_BITS-1]};
      assign diff  = (trial >= {1'b0, inc[a]}) ? (trial - {1'b0, inc[a]}) : trial;

      always_comb begin
         data_in.lane[a]     = in_data.lane[a];
         data_in.lane[a].rem = diff[SIZE_BITS-1:0];
         data_in.lane[a].dvd = {in_data.lane[a].dvd[SIZE_BITS-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/wshc_post.sv =====
// back stages: snap, min and max clamp, then origin and output register
module wshc_post (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  wshc_pkg::cell_data_type                in_data,
   input  wshc_pkg::hint_cfg_type                 cfg,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [wshc_pkg::SIZE_BITS-1:0]         out_width,
   output logic [wshc_pkg::SIZE_BITS-1:0]         out_height,
   output logic signed [wshc_pkg::ORG_BITS-1:0]   out_x,
   output logic signed [wshc_pkg::ORG_BITS-1:0]   out_y
);
   import wshc_pkg::*;

   cell_data_type b_data_in, b_data_ff;
   logic b_valid_ff, o_valid_ff, b_ready, o_ready;
   size_type [1:0] size_ff;
   logic signed [ORG_BITS-1:0] org_in [2];
   logic signed [ORG_BITS-1:0] org_ff [2];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      size_type snapped, lo_clamped;

      always_comb begin
         priority if (!in_data.lane[a].en) begin
            snapped = in_data.lane[a].size;
         end else if (in_data.lane[a].neg) begin
            snapped = in_data.lane[a].size + in_data.lane[a].rem;
         end else begin
            snapped = in_data.lane[a].size - in_data.lane[a].rem;
         end
         lo_clamped = (cfg.flags[FLAG_MIN] && (snapped < cfg.min_sz[a])) ?
                      cfg.min_sz[a] : snapped;
         b_data_in.lane[a]      = in_data.lane[a];
         b_data_in.lane[a].size = (cfg.flags[FLAG_MAX] && (lo_clamped > cfg.max_sz[a])) ?
                                  cfg.max_sz[a] : lo_clamped;
      end

      assign org_in[a] = b_data_ff.lane[a].back ?
                         (b_data_ff.lane[a].anchor - $signed({2'b00, b_data_ff.lane[a].size})) :
                         b_data_ff.lane[a].anchor;
   end

   assign o_ready  = !o_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || o_ready;
   assign in_ready = b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= in_valid;
         end
         if (o_ready) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && in_valid) begin
         b_data_ff <= b_data_in;
      end
      if (o_ready && b_valid_ff) begin
         size_ff[0] <= b_data_ff.lane[0].size;
         size_ff[1] <= b_data_ff.lane[1].size;
         org_ff[0]  <= org_in[0];
         org_ff[1]  <= org_in[1];
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_width  = size_ff[0];
   assign out_height = size_ff[1];
   assign out_x      = org_ff[0];
   assign out_y      = org_ff[1];

endmodule

// ===== hdl/window_size_hint_constrain_top.sv =====
// top level of the window size hint constrain block
// Takes one transaction per cycle while req_stall is low and returns one result per transaction, in
// order: two front stages form the sizes and their offsets from the snap base, a row of 16
// remainder cells works out one bit of the increment remainder each, and two back stages snap,
// clamp and place the origin. Every stage holds its own item, so bubbles close up and new
// transactions are taken while a result waits. Hint registers are to be written through the
// csr port only while no transaction is in flight; the block itself does not enforce this.
module window_size_hint_constrain_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [COORD_BITS-1:0]                req_anchor_x,
   input  logic signed [COORD_BITS-1:0]                req_anchor_y,
   input  logic signed [COORD_BITS-1:0]                req_pointer_x,
   input  logic signed [COORD_BITS-1:0]                req_pointer_y,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [wshc_pkg::SIZE_BITS-1:0]              rsp_rect_width,
   output logic [wshc_pkg::SIZE_BITS-1:0]              rsp_rect_height,
   output logic signed [wshc_pkg::ORG_BITS-1:0]        rsp_rect_x,
   output logic signed [wshc_pkg::ORG_BITS-1:0]        rsp_rect_y,
   input  logic                                        csr_write_en,
   input  logic [wshc_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [wshc_pkg::CSR_DATA_BITS-1:0]          csr_wdata
);
   import wshc_pkg::*;

   logic [FLAG_BITS-1:0]     hint_flags_ff;
   logic [CSR_DATA_BITS-1:0] base_size_ff, min_size_ff, max_size_ff, size_increment_ff;
   hint_cfg_type             cfg;
   logic                     req_ready;

   cell_data_type            chain_data  [CHAIN_CELLS+1];
   logic [CHAIN_CELLS:0]     chain_valid;
   logic [CHAIN_CELLS:0]     chain_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_flags_ff     <= '0;
         base_size_ff      <= '0;
         min_size_ff       <= '0;
         max_size_ff       <= '1;
         size_increment_ff <= 32'h0001_0001;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HINT_FLAGS:     hint_flags_ff     <= csr_wdata[FLAG_BITS-1:0];
            CSR_BASE_SIZE:      base_size_ff      <= csr_wdata;
            CSR_MIN_SIZE:       min_size_ff       <= csr_wdata;
            CSR_MAX_SIZE:       max_size_ff       <= csr_wdata;
            CSR_SIZE_INCREMENT: size_increment_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.flags      = hint_flags_ff;
      cfg.base_sz[0] = base_size_ff[SIZE_BITS-1:0];
      cfg.base_sz[1] = base_size_ff[2*SIZE_BITS-1:SIZE_BITS];
      cfg.min_sz[0]  = min_size_ff[SIZE_BITS-1:0];
      cfg.min_sz[1]  = min_size_ff[2*SIZE_BITS-1:SIZE_BITS];
      cfg.max_sz[0]  = max_size_ff[SIZE_BITS-1:0];
      cfg.max_sz[1]  = max_size_ff[2*SIZE_BITS-1:SIZE_BITS];
      cfg.inc[0]     = size_increment_ff[SIZE_BITS-1:0];
      cfg.inc[1]     = size_increment_ff[2*SIZE_BITS-1:SIZE_BITS];
   end

   assign req_stall = !req_ready;

   wshc_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .anchor_x  (req_anchor_x),
      .anchor_y  (req_anchor_y),
      .pointer_x (req_pointer_x),
      .pointer_y (req_pointer_y),
      .cfg       (cfg),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
      wshc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .inc       (cfg.inc),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   wshc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[CHAIN_CELLS]),
      .in_ready   (chain_ready[CHAIN_CELLS]),
      .in_data    (chain_data[CHAIN_CELLS]),
      .cfg        (cfg),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_width  (rsp_rect_width),
      .out_height (rsp_rect_height),
      .out_x      (rsp_rect_x),
      .out_y      (rsp_rect_y)
   );

endmodule

// ===== hdl/wshc_checker.sv =====
// port checker for the window size hint constrain block, with its bind
`include "window_size_hint_constrain_top_assert.svh"

module wshc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [wshc_pkg::SIZE_BITS-1:0]         rsp_rect_width,
   input logic [wshc_pkg::SIZE_BITS-1:0]         rsp_rect_height,
   input logic signed [wshc_pkg::ORG_BITS-1:0]   rsp_rect_x,
   input logic signed [wshc_pkg::ORG_BITS-1:0]   rsp_rect_y
);
   import wshc_pkg::*;

   localparam int CNT_BITS = $clog2(PIPE_DEPTH + 2);

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic in_acc, out_acc;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;
   assign cnt_in  = cnt_ff + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // stalled result holds
   `WSHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rect_width) && $stable(rsp_rect_height) && $stable(rsp_rect_x) && $stable(rsp_rect_y), "stalled result changed")
   // input only backs up when the whole pipe is full behind a stalled result
   `WSHC_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without a stalled result")
   // no result without a transaction in flight
   `WSHC_ASSERT_IMPL(a_no_invent, rsp_valid, cnt_ff != '0, "result without a pending transaction")
   // occupancy bounded by pipeline depth
   `WSHC_ASSERT_IMPL(a_depth, 1'b1, cnt_ff <= CNT_BITS'(PIPE_DEPTH), "more transactions in flight than stages")

endmodule

bind window_size_hint_constrain_top wshc_checker u_checker (.*);
